FILE: rtl/top_k_min_heap_keeper_macros.svh
// Assertion macros shared by the top-k heap keeper RTL.
`ifndef TOP_K_MIN_HEAP_KEEPER_MACROS_SVH
`define TOP_K_MIN_HEAP_KEEPER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define TKH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkh assertion failed");
// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define TKH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkh assertion failed");
`else
`define TKH_ASSERT_IMPL(lbl, ante, cons)
`define TKH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/tkh_pkg.sv
// Package with types, constants and state codes of the top-k heap keeper.
package tkh_pkg;

  localparam int CAPACITY = 63;
  localparam int HEAP_AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W    = HEAP_AW + 2;
  localparam int SIZE_W   = 6;
  localparam int WIDE_W   = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int SCORE_W  = 32;
  localparam int POS_W    = 16;

  localparam logic [SIZE_W-1:0]         SIZE_RESET = 6'd63;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN  = 32'sh8000_0000;

  typedef enum logic {
    KIND_OFFER = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [POS_W-1:0]            pos_x;
    logic [POS_W-1:0]            pos_y;
    logic signed [SCORE_W-1:0]   score;
  } tkh_in_t;

  typedef struct packed {
    logic [POS_W-1:0]            out_x;
    logic [POS_W-1:0]            out_y;
    logic signed [SCORE_W-1:0]   out_score;
    logic                        out_valid;
    logic                        last;
  } tkh_out_t;

  // One heap slot as held in the memory
  typedef struct packed {
    logic signed [SCORE_W-1:0]   score;
    logic [POS_W-1:0]            x;
    logic [POS_W-1:0]            y;
    logic                        vld;
  } tkh_entry_t;

  localparam tkh_entry_t ENTRY_RESET = '{score: SCORE_MIN, x: '0, y: '0, vld: 1'b0};

  // Request from the sequencer to the heap memory
  typedef struct packed {
    logic                        we;
    logic [HEAP_AW-1:0]          waddr;
    tkh_entry_t                  wdata;
    logic                        re;
    logic [HEAP_AW-1:0]          raddr0;
    logic [HEAP_AW-1:0]          raddr1;
    logic                        clear;
  } tkh_mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_ROOT,
    ST_LEVEL,
    ST_CMP_CH,
    ST_CMP_NEW,
    ST_DR_LD
  } tkh_state_t;

endpackage

FILE: rtl/tkh_cmp.sv
// Shared signed score comparator used for every comparison of the sift.
module tkh_cmp
  import tkh_pkg::*;
(
  input  logic signed [SCORE_W-1:0] a,
  input  logic signed [SCORE_W-1:0] b,
  output logic                      a_gt_b
);

  // Compare two's complement scores
  assign a_gt_b = (a > b);

endmodule

FILE: rtl/tkh_mem.sv
// Heap storage: one write port, two registered read ports, per-slot written flags.
module tkh_mem
  import tkh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tkh_mem_req_t req,
  output tkh_entry_t   rd0,
  output tkh_entry_t   rd1
);

  tkh_entry_t          mem_r [CAPACITY];
  logic [CAPACITY-1:0] wr_flag_r;
  tkh_entry_t          rd0_r;
  tkh_entry_t          rd1_r;

  // Write the array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Track written slots; drop them all on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_flag_r <= '0;
    end else if (req.clear) begin
      wr_flag_r <= '0;
    end else if (req.we) begin
      wr_flag_r[req.waddr] <= 1'b1;
    end
  end

  // Read two slots; unwritten slots read as empty
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd0_r <= wr_flag_r[req.raddr0] ? mem_r[req.raddr0] : ENTRY_RESET;
      rd1_r <= wr_flag_r[req.raddr1] ? mem_r[req.raddr1] : ENTRY_RESET;
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

FILE: rtl/top_k_min_heap_keeper.sv
// Top-k min-heap keeper: offer sifts a candidate down, drain streams and clears the heap.
// Offer: an item that does not beat the root is dropped; else it replaces the root and sifts
// down, each level reading both children, picking the smaller and moving it up if beaten.
// Drain: n results, one per cycle while out_ready holds, in heap array order.
// Rate is set by one shared comparator and the two-port heap memory, one step per cycle.
// rst_n (synchronous, active low) empties the heap and sets size_r (K) to 63.
`include "top_k_min_heap_keeper_macros.svh"
module top_k_min_heap_keeper
  import tkh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tkh_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tkh_out_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  tkh_state_t         state_r, state_nxt;
  logic [SIZE_W-1:0]  size_r;
  logic [HEAP_AW-1:0] node_r, node_nxt;
  logic [HEAP_AW-1:0] idx_r, idx_nxt;
  logic [HEAP_AW-1:0] child_idx_r, child_idx_nxt;
  logic               r_exists_r, r_exists_nxt;
  tkh_entry_t         item_r, item_nxt;
  tkh_entry_t         child_r, child_nxt;
  tkh_out_t           out_r;
  logic               out_vld_r;

  tkh_mem_req_t       mem_req;
  tkh_entry_t         rd0, rd1;
  logic signed [SCORE_W-1:0] cmp_a, cmp_b;
  logic               cmp_gt;

  logic [WIDE_W-1:0]  size_w, n_w, left_w, right_w;
  logic               n_zero, has_left, has_right, is_last;
  logic               in_accept, out_free, out_load;

  tkh_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rd0   (rd0),
    .rd1   (rd1)
  );

  tkh_cmp u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .a_gt_b (cmp_gt)
  );

  // Clamp the entry count and derive child indexes
  assign size_w    = WIDE_W'(size_r);
  assign n_w       = (size_w > WIDE_W'(CAPACITY)) ? WIDE_W'(CAPACITY) : size_w;
  assign n_zero    = (n_w == '0);
  assign left_w    = WIDE_W'({node_r, 1'b1});
  assign right_w   = left_w + WIDE_W'(1);
  assign has_left  = (left_w < n_w);
  assign has_right = (right_w < n_w);
  assign is_last   = ((WIDE_W'(idx_r) + WIDE_W'(1)) == n_w);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_vld_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && !n_zero) begin
          state_nxt = (in_data.kind == KIND_OFFER) ? ST_CMP_ROOT : ST_DR_LD;
        end
      end
      ST_CMP_ROOT: begin
        state_nxt = cmp_gt ? ST_LEVEL : ST_IDLE;
      end
      ST_LEVEL: begin
        state_nxt = has_left ? ST_CMP_CH : ST_IDLE;
      end
      ST_CMP_CH: begin
        state_nxt = ST_CMP_NEW;
      end
      ST_CMP_NEW: begin
        state_nxt = cmp_gt ? ST_LEVEL : ST_IDLE;
      end
      ST_DR_LD: begin
        if (out_free && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory requests, comparator operands and datapath updates
  always_comb begin
    mem_req       = '0;
    cmp_a         = item_r.score;
    cmp_b         = rd0.score;
    node_nxt      = node_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    child_nxt     = child_r;
    child_idx_nxt = child_idx_r;
    r_exists_nxt  = r_exists_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt = '{score: in_data.score, x: in_data.pos_x, y: in_data.pos_y, vld: 1'b1};
          node_nxt = '0;
          idx_nxt  = '0;
          if (n_zero) begin
            mem_req.clear = (in_data.kind == KIND_DRAIN);
          end else begin
            mem_req.re     = 1'b1;
            mem_req.raddr0 = '0;
            mem_req.raddr1 = '0;
          end
        end
      end
      ST_CMP_ROOT: begin
        // item against the root read last cycle
        cmp_a = item_r.score;
        cmp_b = rd0.score;
      end
      ST_LEVEL: begin
        if (has_left) begin
          mem_req.re     = 1'b1;
          mem_req.raddr0 = left_w[HEAP_AW-1:0];
          mem_req.raddr1 = has_right ? right_w[HEAP_AW-1:0] : left_w[HEAP_AW-1:0];
          r_exists_nxt   = has_right;
        end else begin
          // leaf reached: settle the item here
          mem_req.we    = 1'b1;
          mem_req.waddr = node_r;
          mem_req.wdata = item_r;
        end
      end
      ST_CMP_CH: begin
        // pick the smaller child, ties go left
        cmp_a = rd0.score;
        cmp_b = rd1.score;
        if (r_exists_r && cmp_gt) begin
          child_nxt     = rd1;
          child_idx_nxt = right_w[HEAP_AW-1:0];
        end else begin
          child_nxt     = rd0;
          child_idx_nxt = left_w[HEAP_AW-1:0];
        end
      end
      ST_CMP_NEW: begin
        cmp_a         = item_r.score;
        cmp_b         = child_r.score;
        mem_req.we    = 1'b1;
        mem_req.waddr = node_r;
        if (cmp_gt) begin
          // move the child up and descend
          mem_req.wdata = child_r;
          node_nxt      = child_idx_r;
        end else begin
          mem_req.wdata = item_r;
        end
      end
      ST_DR_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_last) begin
            mem_req.clear = 1'b1;
          end else begin
            idx_nxt        = idx_r + HEAP_AW'(1);
            mem_req.re     = 1'b1;
            mem_req.raddr0 = idx_r + HEAP_AW'(1);
            mem_req.raddr1 = idx_r + HEAP_AW'(1);
          end
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    idx_r       <= idx_nxt;
    item_r      <= item_nxt;
    child_r     <= child_nxt;
    child_idx_r <= child_idx_nxt;
    r_exists_r  <= r_exists_nxt;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= '{out_x: rd0.x, out_y: rd0.y, out_score: rd0.score,
                 out_valid: rd0.vld, last: is_last};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `TKH_ASSERT_IMPL(a_node_range, state_r == ST_LEVEL, WIDE_W'(node_r) < n_w)
  `TKH_ASSERT_IMPL(a_write_range, mem_req.we, WIDE_W'(mem_req.waddr) < n_w)
  `TKH_ASSERT_NEXT(a_drain_end, out_load && is_last, (state_r == ST_IDLE) && out_valid)
  `TKH_ASSERT_NEXT(a_offer_silent, in_accept && (in_data.kind == KIND_OFFER), !out_load)

endmodule

FILE: bench/top_k_min_heap_keeper_tb.sv
// Self-checking testbench for the top-k min-heap keeper: shadow heap, random offers and drains.
`timescale 1ns / 100ps

module top_k_min_heap_keeper_tb
  import tkh_pkg::*;
();

  localparam int CLK_HALF     = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  tkh_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tkh_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Shadow copy of the heap and the K setting
  tkh_entry_t        shadow_heap [CAPACITY];
  logic [SIZE_W-1:0] shadow_size;
  tkh_out_t          pending_entries [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int drains_sent     = 0;
  int entries_checked = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  top_k_min_heap_keeper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d entries still pending", cycle_count,
               pending_entries.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result transaction against the oldest pending entry
  always @(posedge clk) begin
    tkh_out_t want;
    if (rst_n && out_valid && out_ready) begin
      entries_checked++;
      if (pending_entries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: x=%h y=%h score=%h vld=%b last=%b",
                   out_data.out_x, out_data.out_y, out_data.out_score,
                   out_data.out_valid, out_data.last);
      end else begin
        want = pending_entries.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_score !== want.out_score ||
            out_data.out_valid !== want.out_valid || out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: exp x=%h y=%h score=%h vld=%b last=%b, ",
                      "got x=%h y=%h score=%h vld=%b last=%b"},
                     want.out_x, want.out_y, want.out_score, want.out_valid, want.last,
                     out_data.out_x, out_data.out_y, out_data.out_score,
                     out_data.out_valid, out_data.last);
        end
      end
    end
  end

  function automatic int shadow_slots();
    int n;
    n = shadow_size;
    if (n > CAPACITY) n = CAPACITY;
    return n;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < CAPACITY; i++) shadow_heap[i] = ENTRY_RESET;
  endfunction

  // Replace the root when beaten, then sift it down (ties go to the left child)
  function automatic void offer_to_shadow(tkh_in_t cand);
    int n;
    int node;
    int child;
    tkh_entry_t tmp;
    n = shadow_slots();
    if (n == 0) return;
    if (cand.score <= shadow_heap[0].score) return;
    shadow_heap[0] = '{score: cand.score, x: cand.pos_x, y: cand.pos_y, vld: 1'b1};
    node = 0;
    while (node * 2 + 1 < n) begin
      child = node * 2 + 1;
      if (child + 1 < n && shadow_heap[child].score > shadow_heap[child + 1].score)
        child++;
      if (shadow_heap[node].score <= shadow_heap[child].score) break;
      tmp = shadow_heap[node];
      shadow_heap[node] = shadow_heap[child];
      shadow_heap[child] = tmp;
      node = child;
    end
  endfunction

  // Queue every used entry in array order, then empty the whole heap
  function automatic void drain_shadow();
    int n;
    tkh_out_t r;
    n = shadow_slots();
    for (int i = 0; i < n; i++) begin
      r.out_x     = shadow_heap[i].x;
      r.out_y     = shadow_heap[i].y;
      r.out_score = shadow_heap[i].score;
      r.out_valid = shadow_heap[i].vld;
      r.last      = (i == n - 1);
      pending_entries.push_back(r);
    end
    clear_shadow();
  endfunction

  function automatic tkh_in_t make_item(kind_t k, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                        logic signed [SCORE_W-1:0] s);
    tkh_in_t it;
    it.kind  = k;
    it.pos_x = x;
    it.pos_y = y;
    it.score = s;
    return it;
  endfunction

  function automatic logic signed [SCORE_W-1:0] random_score();
    case ($urandom_range(0, 7))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2, 3:    return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  // Send one input transaction, with random idle cycles ahead of it
  task automatic send_item(tkh_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (item.kind == KIND_OFFER) begin
      offer_to_shadow(item);
    end else begin
      drains_sent++;
      drain_shadow();
    end
  endtask

  // Drop valid and wait until all results are in and any sift has finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_size = value;
  endtask

  // Drain right after reset: every entry empty, K at its reset value
  task automatic test_reset_drain();
    send_item(make_item(KIND_DRAIN, '0, '0, '0));
  endtask

  // Field extremes, dropped offers, equal scores and child ties
  task automatic test_field_extremes();
    write_size(6'd7);
    send_item(make_item(KIND_OFFER, 16'hffff, 16'hffff, SCORE_MIN));
    send_item(make_item(KIND_OFFER, 16'hffff, 16'h0000, SCORE_MAX));
    send_item(make_item(KIND_OFFER, 16'h0000, 16'hffff, 32'sd0));
    send_item(make_item(KIND_OFFER, 16'h1234, 16'h5678, 32'sd5));
    send_item(make_item(KIND_OFFER, 16'h0001, 16'h0002, 32'sd5));
    send_item(make_item(KIND_OFFER, 16'h0003, 16'h0004, 32'sd5));
    send_item(make_item(KIND_OFFER, 16'h0005, 16'h0006, -32'sd1));
    send_item(make_item(KIND_OFFER, 16'h0007, 16'h0008, 32'sd5));
    send_item(make_item(KIND_OFFER, 16'haaaa, 16'h5555, 32'sd5));
    send_item(make_item(KIND_OFFER, 16'h5555, 16'haaaa, 32'sd6));
    send_item(make_item(KIND_DRAIN, 16'hffff, 16'hffff, SCORE_MAX));
  endtask

  // Shrink K over a partly filled heap: drain shows the first K entries only but clears all
  task automatic test_size_shrink();
    write_size(6'd63);
    for (int i = 0; i < 5; i++)
      send_item(make_item(KIND_OFFER, 16'(i + 1), 16'(i + 10), 32'sd100 - i));
    write_size(6'd3);
    send_item(make_item(KIND_DRAIN, '0, '0, '0));
    write_size(6'd63);
    send_item(make_item(KIND_DRAIN, '0, '0, '0));
  endtask

  // K of zero: offers ignored, drain silent yet still clears; then K of one
  task automatic test_zero_size();
    write_size(6'd1);
    send_item(make_item(KIND_OFFER, 16'h00aa, 16'h00bb, 32'sd42));
    write_size(6'd0);
    send_item(make_item(KIND_OFFER, 16'h0011, 16'h0022, SCORE_MAX));
    send_item(make_item(KIND_DRAIN, '0, '0, '0));
    write_size(6'd1);
    send_item(make_item(KIND_DRAIN, '0, '0, '0));
  endtask

  // Random offers with occasional drains under one idling pattern
  task automatic test_random_traffic(int idle_pct, int stall_pct, logic [SIZE_W-1:0] k_size,
                                     int count, int drain_pct);
    tkh_in_t it;
    write_size(k_size);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      it = make_item(($urandom_range(0, 99) < drain_pct) ? KIND_DRAIN : KIND_OFFER,
                     POS_W'($urandom), POS_W'($urandom), random_score());
      send_item(it);
    end
    send_item(make_item(KIND_DRAIN, POS_W'($urandom), POS_W'($urandom), random_score()));
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    shadow_size = SIZE_RESET;
    clear_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_drain();
    test_field_extremes();
    test_size_shrink();
    test_zero_size();
    test_random_traffic(0, 0, 6'd63, 80, 4);
    test_random_traffic(64, 0, 6'd1, 80, 15);
    test_random_traffic(0, 64, 6'($urandom_range(2, 62)), 80, 10);
    test_random_traffic(35, 35, 6'd63, 80, 5);

    wait_idle();
    if (pending_entries.size() != 0) mismatch_count++;
    $display("Covered %0d input items (%0d drains) and %0d heap entries read out,",
             items_sent, drains_sent, entries_checked);
    $display("over K settings 0, 1, 3, 7, 63 and one random, with and without idling.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
